// ----- hw/rtl/sfcc_pkg.sv -----
`timescale 1ns / 1ps

package sfcc_pkg;

  // CRC-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion constants, hundredths of a unit
  localparam int unsigned TEMP_SCALE  = 17500;
  localparam int unsigned TEMP_OFFSET = 4500;
  localparam int unsigned HUM_SCALE   = 10000;

  // Default queue depths
  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_e;

  // One assembled frame, front to back
  typedef struct packed {
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    status_e     status;
  } frame_t;

  // One finished result
  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [15:0]        raw_t;
    logic [15:0]        raw_h;
    status_e            status;
  } result_t;

  // One byte of CRC, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/sfcc_fifo.sv -----
`timescale 1ns / 1ps

module sfcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fifo count beyond depth");

endmodule

// ----- hw/rtl/sfcc_front.sv -----
`timescale 1ns / 1ps

// Byte framing and CRC check; emits one frame record per sixth byte.
module sfcc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            frame_start_i,
  output logic            push_o,
  output sfcc_pkg::frame_t frame_o
);

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_next;
  logic [15:0] tword_q, tword_d, hword_q, hword_d;
  logic        tbad_q, tbad_d;

  assign pos_eff  = (frame_start_i || pos_q > POS_H_CRC) ? POS_T_MSB : pos_q;
  assign crc_next = sfcc_pkg::crc8_step(crc_q, rx_byte_i);

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    tword_d = tword_q;
    hword_d = hword_q;
    tbad_d  = tbad_q;
    push_o  = 1'b0;
    frame_o.raw_t  = tword_q;
    frame_o.raw_h  = hword_q;
    frame_o.status = sfcc_pkg::STATUS_OK;
    if (tbad_q) begin
      frame_o.status = sfcc_pkg::STATUS_TEMP_CRC;
    end else if (crc_q != rx_byte_i) begin
      frame_o.status = sfcc_pkg::STATUS_HUM_CRC;
    end
    if (valid_i) begin
      pos_d = pos_eff + 3'd1;
      case (pos_eff)
        POS_T_MSB: begin
          crc_d   = sfcc_pkg::crc8_step(sfcc_pkg::CRC_INIT, rx_byte_i);
          tword_d = {rx_byte_i, 8'h00};
        end
        POS_T_LSB: begin
          crc_d   = crc_next;
          tword_d = {tword_q[15:8], rx_byte_i};
        end
        POS_T_CRC: begin
          tbad_d = (crc_q != rx_byte_i);
          crc_d  = sfcc_pkg::CRC_INIT;
        end
        POS_H_MSB: begin
          crc_d   = sfcc_pkg::crc8_step(sfcc_pkg::CRC_INIT, rx_byte_i);
          hword_d = {rx_byte_i, 8'h00};
        end
        POS_H_LSB: begin
          crc_d   = crc_next;
          hword_d = {hword_q[15:8], rx_byte_i};
        end
        POS_H_CRC: begin
          crc_d  = sfcc_pkg::CRC_INIT;
          pos_d  = POS_T_MSB;
          push_o = 1'b1;
        end
        default: begin
          pos_d = POS_T_MSB;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_T_MSB;
      crc_q   <= sfcc_pkg::CRC_INIT;
      tword_q <= '0;
      hword_q <= '0;
      tbad_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tword_q <= tword_d;
      hword_q <= hword_d;
      tbad_q  <= tbad_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_H_CRC)
    else $error("byte position out of range");

  a_wrap_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == POS_T_MSB) && (crc_q == sfcc_pkg::CRC_INIT))
    else $error("position or crc not restarted after frame");

endmodule

// ----- hw/rtl/sfcc_back.sv -----
`timescale 1ns / 1ps

// Fixed-point conversion: multiply stage, then divide-by-65535 and offset stage.
module sfcc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  sfcc_pkg::frame_t  frame_i,
  output logic              pop_o,
  input  logic              full_i,
  output logic              push_o,
  output sfcc_pkg::result_t result_o
);

  // floor(x / 65535) for x < 2^31: (x + (x >> 16) + 1) >> 16
  function automatic logic [15:0] div65535(input logic [30:0] x);
    logic [32:0] s;
    s = 33'(x) + 33'(x[30:16]) + 33'd1;
    return s[31:16];
  endfunction

  logic             en;
  logic             s1_v_q, s2_v_q;
  sfcc_pkg::frame_t s1_q;
  logic [30:0]      prod_t_q;
  logic [29:0]      prod_h_q;
  sfcc_pkg::result_t s2_q, s2_d;
  logic [15:0]      q_t, q_h;
  logic signed [15:0] t_wide;

  assign en     = !s2_v_q || !full_i;
  assign pop_o  = !empty_i && en;
  assign push_o = s2_v_q;
  assign result_o = s2_q;

  assign q_t    = div65535(prod_t_q);
  assign q_h    = div65535({1'b0, prod_h_q});
  assign t_wide = $signed(q_t) - 16'(sfcc_pkg::TEMP_OFFSET);

  always_comb begin
    s2_d.raw_t      = s1_q.raw_t;
    s2_d.raw_h      = s1_q.raw_h;
    s2_d.status     = s1_q.status;
    s2_d.temp_centi = '0;
    s2_d.hum_centi  = '0;
    if (s1_q.status == sfcc_pkg::STATUS_OK) begin
      s2_d.temp_centi = t_wide[14:0];
      s2_d.hum_centi  = q_h[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= pop_o;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= frame_i;
      prod_t_q <= 31'(frame_i.raw_t) * 31'(sfcc_pkg::TEMP_SCALE);
      prod_h_q <= 30'(frame_i.raw_h) * 30'(sfcc_pkg::HUM_SCALE);
      s2_q     <= s2_d;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && full_i) |=> s2_v_q && $stable(s2_q))
    else $error("result lost while output queue full");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_q.status != sfcc_pkg::STATUS_OK) |->
      (s2_q.temp_centi == '0) && (s2_q.hum_centi == '0))
    else $error("converted value not zero on crc error");

  a_no_status3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_q.status == sfcc_pkg::STATUS_OK ||
                s2_q.status == sfcc_pkg::STATUS_TEMP_CRC ||
                s2_q.status == sfcc_pkg::STATUS_HUM_CRC))
    else $error("invalid status code");

endmodule

// ----- hw/rtl/sensor_frame_crc_convert_core.sv -----
`timescale 1ns / 1ps
// A frame goes through the frame queue, the multiply and divide stages, and the output queue.
// Input: one byte per cycle while the frame queue has room; one result per six bytes.
// Behind a queue, conversion (multiply, divide by 65535) takes one frame per cycle unless stalled.
// Reset (rst_ni, async, active low) restarts framing at byte 0, CRC at 0xFF, empties both queues.
// A full output queue stalls the converter; the input stalls only once the frame queue fills.

module sensor_frame_crc_convert_core #(
  parameter int unsigned MID_DEPTH = sfcc_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = sfcc_pkg::OUT_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input byte channel
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic [15:0]        raw_temperature_o,
  output logic [15:0]        raw_humidity_o,
  output logic [1:0]         status_o
);

  localparam int unsigned FRAME_W  = $bits(sfcc_pkg::frame_t);
  localparam int unsigned RESULT_W = $bits(sfcc_pkg::result_t);

  logic              byte_xfer;
  logic              fr_push, mid_full, mid_empty, mid_pop;
  sfcc_pkg::frame_t  fr_front, fr_mid;
  logic [FRAME_W-1:0] fr_mid_bits;
  logic              res_push, out_full;
  sfcc_pkg::result_t res_back, res_out;
  logic [RESULT_W-1:0] res_out_bits;

  // A byte transfers whenever the frame queue has room; only the
  // sixth byte of a frame ever writes into it.
  assign full      = mid_full;
  assign byte_xfer = push && !mid_full;

  // Front: position counter, word assembly, CRC check.
  sfcc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (byte_xfer),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (fr_push),
    .frame_o       (fr_front)
  );

  // Decoupling queue between framing and conversion.
  sfcc_fifo #(
    .WIDTH (FRAME_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  (fr_front),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (fr_mid_bits),
    .empty_o (mid_empty)
  );

  assign fr_mid = sfcc_pkg::frame_t'(fr_mid_bits);

  // Back: two-stage converter with stall from the output queue.
  sfcc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (mid_empty),
    .frame_i  (fr_mid),
    .pop_o    (mid_pop),
    .full_i   (out_full),
    .push_o   (res_push),
    .result_o (res_back)
  );

  // Output queue; its head drives the result ports.
  sfcc_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_back),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .empty_o (empty)
  );

  assign res_out             = sfcc_pkg::result_t'(res_out_bits);
  assign temperature_centi_o = res_out.temp_centi;
  assign humidity_centi_o    = res_out.hum_centi;
  assign raw_temperature_o   = res_out.raw_t;
  assign raw_humidity_o      = res_out.raw_h;
  assign status_o            = res_out.status;

endmodule
